// File: rtl/core/mqas_pkg.sv
// mqas_pkg: shared types, codes and helpers of the mdns query and announce scheduler
// used by mqas_engine and mdns_query_announce_scheduler_unit
`default_nettype none

package mqas_pkg;

  // field widths
  localparam int unsigned TIME_W = 48;
  localparam int unsigned IVL_W = 16;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned EV_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // result budget of one tick
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // default table sizes
  localparam int unsigned QUERY_SLOTS_DEF = 8;
  localparam int unsigned ANNOUNCE_SLOTS_DEF = 8;

  // input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 3'd0,
    KIND_RESOLVE   = 3'd1,
    KIND_CANCEL    = 3'd2,
    KIND_ANSWER    = 3'd3,
    KIND_PUBLISH   = 3'd4,
    KIND_UNPUBLISH = 3'd5
  } kind_e;

  // result event codes
  typedef enum logic [EV_W-1:0] {
    EV_SEND_QUERY = 3'd0,
    EV_RESOLVED   = 3'd1,
    EV_TIMED_OUT  = 3'd2,
    EV_CANCELLED  = 3'd3,
    EV_ANNOUNCE   = 3'd4,
    EV_GOODBYE    = 3'd5
  } ev_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_QUERY_IVL  = 3'd1,
    CFG_QUERY_MAX  = 3'd2,
    CFG_ANN_IVL    = 3'd3,
    CFG_ANN_MAX    = 3'd4,
    CFG_DEF_TMO    = 3'd5
  } cfg_idx_e;

  // engine sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_QWALK,
    ST_QEXP,
    ST_AWALK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             enabled;
    logic [IVL_W-1:0] q_ivl;
    logic [CNT_W-1:0] q_max;
    logic [IVL_W-1:0] a_ivl;
    logic [CNT_W-1:0] a_max;
    logic [IVL_W-1:0] def_tmo;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enabled: 1'b0,
    q_ivl:   16'd1000,
    q_max:   4'd3,
    a_ivl:   16'd1000,
    a_max:   4'd3,
    def_tmo: 16'd5000
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
    logic [IVL_W-1:0]  tmo;
  } item_t;

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } res_t;

  // query table entry
  typedef struct packed {
    logic [TIME_W-1:0] next_send;
    logic [TIME_W-1:0] expiry;
    logic [CNT_W-1:0]  cnt;
  } qent_t;

  // announcement table entry
  typedef struct packed {
    logic [TIME_W-1:0] next_send;
    logic [CNT_W-1:0]  cnt;
  } aent_t;

  // time plus interval, saturating at the top of the time range
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [IVL_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - IVL_W){1'b0}}, d};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mdns_query_announce_scheduler_unit.sv
// mdns_query_announce_scheduler_unit: top level with stream ports, configuration
// registers and the output register; depends on mqas_pkg and mqas_engine
//
// Usage: items enter on the s_axis channel (tuser = kind, tdata = slot, now, timeout)
// and events leave on the m_axis channel (tuser = event, tdata = slot, tlast marks
// the final event caused by one item). Configuration registers are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so only while no item is in
// flight, as the block itself does not enforce it. Throughput: one item at a time.
// A resolve, cancel, answer, publish or unpublish passes through the decode and
// finish states before the next item can be accepted. A tick walks the query table
// one slot per cycle, then emits one timeout per cycle, then walks the announcement
// table one slot per cycle, each step waiting while the output register is full and
// the walks ending early once the result budget is spent; each table memory is updated
// by a read-modify-write of one entry per step. Events are held back in the engine
// until the next event or the end of the item, so that tlast can mark the final one.
// Reset: configuration returns to defaults and all slots become free; the table
// memories need no clearing since an entry is read only while its slot is valid.
// Stall: a full output register freezes the walk at the current slot without
// losing state; items are not accepted until the current one finishes.
`default_nettype none

module mdns_query_announce_scheduler_unit #(
  parameter int unsigned QUERY_SLOTS    = mqas_pkg::QUERY_SLOTS_DEF,
  parameter int unsigned ANNOUNCE_SLOTS = mqas_pkg::ANNOUNCE_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // item input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // slot[2:0], now_ms[50:3], timeout_ms[66:51]
  input  wire logic [2:0]  s_axis_tuser,   // kind[2:0]
  // event output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // slot_out[2:0]
  output logic [2:0]       m_axis_tuser,   // event_res[2:0]
  output logic             m_axis_tlast    // last
);

  mqas_pkg::cfg_t  cfg_q, cfg_d;
  mqas_pkg::item_t item;
  mqas_pkg::res_t  res, out_q;
  logic            res_valid, res_ready, out_v_q;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mqas_pkg::CFG_ENABLE:    cfg_d.enabled = cfg_wdata_i[0];
        mqas_pkg::CFG_QUERY_IVL: cfg_d.q_ivl   = cfg_wdata_i;
        mqas_pkg::CFG_QUERY_MAX: cfg_d.q_max   = cfg_wdata_i[mqas_pkg::CNT_W-1:0];
        mqas_pkg::CFG_ANN_IVL:   cfg_d.a_ivl   = cfg_wdata_i;
        mqas_pkg::CFG_ANN_MAX:   cfg_d.a_max   = cfg_wdata_i[mqas_pkg::CNT_W-1:0];
        mqas_pkg::CFG_DEF_TMO:   cfg_d.def_tmo = cfg_wdata_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mqas_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // unpack the input item
  assign item = '{kind: s_axis_tuser,
                  slot: s_axis_tdata[2:0],
                  now:  s_axis_tdata[50:3],
                  tmo:  s_axis_tdata[66:51]};

  mqas_engine #(
    .QUERY_SLOTS    (QUERY_SLOTS),
    .ANNOUNCE_SLOTS (ANNOUNCE_SLOTS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register
  assign res_ready = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_valid) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_q.slot};
  assign m_axis_tuser  = out_q.ev;
  assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

// File: rtl/core/mqas_engine.sv
// mqas_engine: query and announcement tables in two synchronous memories, valid bits,
// and the sequencer that runs commands and tick walks; depends on mqas_pkg
`default_nettype none

module mqas_engine #(
  parameter int unsigned QUERY_SLOTS    = mqas_pkg::QUERY_SLOTS_DEF,
  parameter int unsigned ANNOUNCE_SLOTS = mqas_pkg::ANNOUNCE_SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mqas_pkg::cfg_t cfg_i,
  input  wire logic           item_valid_i,
  output logic                item_ready_o,
  input  wire mqas_pkg::item_t item_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output mqas_pkg::res_t      res_o
);

  localparam int unsigned QIW = (QUERY_SLOTS > 1) ? $clog2(QUERY_SLOTS) : 1;
  localparam int unsigned AIW = (ANNOUNCE_SLOTS > 1) ? $clog2(ANNOUNCE_SLOTS) : 1;
  localparam int unsigned RCW = mqas_pkg::RES_CNT_W;

  mqas_pkg::state_e state_q, state_d;
  mqas_pkg::item_t  item_q, item_d;
  logic [QIW-1:0]   qidx_q, qidx_d;
  logic [AIW-1:0]   aidx_q, aidx_d;
  logic [RCW-1:0]   cnt_q, cnt_d;
  logic [QUERY_SLOTS-1:0]    expmask_q, expmask_d;
  logic [QUERY_SLOTS-1:0]    qvalid_q, qvalid_d;
  logic [ANNOUNCE_SLOTS-1:0] avalid_q, avalid_d;

  // held-back result, released once it is known whether more follow
  logic                          hold_v_q, hold_v_d;
  logic [mqas_pkg::EV_W-1:0]     hold_ev_q, hold_ev_d;
  logic [mqas_pkg::SLOT_W-1:0]   hold_slot_q, hold_slot_d;

  // memory ports
  mqas_pkg::qent_t qmem [QUERY_SLOTS];
  mqas_pkg::aent_t amem [ANNOUNCE_SLOTS];
  mqas_pkg::qent_t q_rdata_q, q_wdata;
  mqas_pkg::aent_t a_rdata_q, a_wdata;
  logic            q_we, a_we;
  logic [QIW-1:0]  q_waddr, q_raddr;
  logic [AIW-1:0]  a_waddr, a_raddr;

  // decode helpers
  logic                        can_emit, emit_new, q_adv, a_adv;
  logic [mqas_pkg::EV_W-1:0]   new_ev;
  logic [mqas_pkg::SLOT_W-1:0] new_slot;
  logic [QIW-1:0]              slot_qi, exp_idx;
  logic [AIW-1:0]              slot_ai;
  logic                        q_in_range, a_in_range, full;
  logic [mqas_pkg::IVL_W-1:0]  tmo_eff;

  assign can_emit   = !hold_v_q || res_ready_i;
  assign slot_qi    = QIW'(item_q.slot);
  assign slot_ai    = AIW'(item_q.slot);
  assign q_in_range = int'(item_q.slot) < QUERY_SLOTS;
  assign a_in_range = int'(item_q.slot) < ANNOUNCE_SLOTS;
  assign full       = cnt_q >= RCW'(mqas_pkg::MAX_RESULTS);
  assign tmo_eff    = (item_q.tmo == '0) ? cfg_i.def_tmo : item_q.tmo;

  // lowest pending expiration
  always_comb begin
    exp_idx = '0;
    for (int i = QUERY_SLOTS - 1; i >= 0; i--) begin
      if (expmask_q[i]) begin
        exp_idx = QIW'(i);
      end
    end
  end

  // memories, read data registered
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= qmem[q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    a_rdata_q <= amem[a_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mqas_pkg::ST_IDLE;
      qidx_q    <= '0;
      aidx_q    <= '0;
      cnt_q     <= '0;
      expmask_q <= '0;
      qvalid_q  <= '0;
      avalid_q  <= '0;
      hold_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      qidx_q    <= qidx_d;
      aidx_q    <= aidx_d;
      cnt_q     <= cnt_d;
      expmask_q <= expmask_d;
      qvalid_q  <= qvalid_d;
      avalid_q  <= avalid_d;
      hold_v_q  <= hold_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    hold_ev_q   <= hold_ev_d;
    hold_slot_q <= hold_slot_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    qidx_d      = qidx_q;
    aidx_d      = aidx_q;
    cnt_d       = cnt_q;
    expmask_d   = expmask_q;
    qvalid_d    = qvalid_q;
    avalid_d    = avalid_q;
    hold_v_d    = hold_v_q;
    hold_ev_d   = hold_ev_q;
    hold_slot_d = hold_slot_q;
    emit_new    = 1'b0;
    new_ev      = mqas_pkg::EV_SEND_QUERY;
    new_slot    = item_q.slot;
    q_adv       = 1'b0;
    a_adv       = 1'b0;
    q_we        = 1'b0;
    q_waddr     = qidx_q;
    q_wdata     = q_rdata_q;
    a_we        = 1'b0;
    a_waddr     = aidx_q;
    a_wdata     = a_rdata_q;
    item_ready_o = (state_q == mqas_pkg::ST_IDLE);
    res_valid_o  = 1'b0;

    case (state_q)
      mqas_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = mqas_pkg::ST_CMD;
        end
      end

      mqas_pkg::ST_CMD: begin
        state_d = mqas_pkg::ST_FIN;
        case (item_q.kind)
          mqas_pkg::KIND_TICK: begin
            if (cfg_i.enabled) begin
              qidx_d    = '0;
              cnt_d     = '0;
              expmask_d = '0;
              state_d   = mqas_pkg::ST_QWALK;
            end
          end
          mqas_pkg::KIND_RESOLVE: begin
            if (q_in_range) begin
              if (!cfg_i.enabled) begin
                emit_new = 1'b1;
                new_ev   = mqas_pkg::EV_TIMED_OUT;
              end else if (!qvalid_q[slot_qi]) begin
                qvalid_d[slot_qi] = 1'b1;
                q_we              = 1'b1;
                q_waddr           = slot_qi;
                q_wdata.next_send = item_q.now;
                q_wdata.expiry    = mqas_pkg::sat_add(item_q.now, tmo_eff);
                q_wdata.cnt       = '0;
                emit_new          = 1'b1;
                new_ev            = mqas_pkg::EV_SEND_QUERY;
              end
            end
          end
          mqas_pkg::KIND_CANCEL, mqas_pkg::KIND_ANSWER: begin
            if (q_in_range && qvalid_q[slot_qi]) begin
              qvalid_d[slot_qi] = 1'b0;
              emit_new          = 1'b1;
              new_ev            = (item_q.kind == mqas_pkg::KIND_CANCEL) ?
                                  mqas_pkg::EV_CANCELLED : mqas_pkg::EV_RESOLVED;
            end
          end
          mqas_pkg::KIND_PUBLISH: begin
            if (a_in_range && cfg_i.enabled) begin
              avalid_d[slot_ai] = 1'b1;
              a_we              = 1'b1;
              a_waddr           = slot_ai;
              a_wdata.next_send = item_q.now;
              a_wdata.cnt       = '0;
            end
          end
          mqas_pkg::KIND_UNPUBLISH: begin
            if (a_in_range && avalid_q[slot_ai]) begin
              avalid_d[slot_ai] = 1'b0;
              emit_new          = cfg_i.enabled;
              new_ev            = mqas_pkg::EV_GOODBYE;
            end
          end
          default: begin
            state_d = mqas_pkg::ST_FIN;
          end
        endcase
      end

      // one query slot per cycle while the output can take a result; the next entry is read meanwhile
      mqas_pkg::ST_QWALK: begin
        new_slot = mqas_pkg::SLOT_W'(qidx_q);
        if (!qvalid_q[qidx_q]) begin
          q_adv = 1'b1;
        end else if (full) begin
          state_d = mqas_pkg::ST_QEXP;
        end else if (item_q.now >= q_rdata_q.expiry) begin
          qvalid_d[qidx_q]  = 1'b0;
          expmask_d[qidx_q] = 1'b1;
          cnt_d             = cnt_q + RCW'(1);
          q_adv             = 1'b1;
        end else if (q_rdata_q.cnt < cfg_i.q_max &&
                     item_q.now >= q_rdata_q.next_send) begin
          if (can_emit) begin
            emit_new          = 1'b1;
            new_ev            = mqas_pkg::EV_SEND_QUERY;
            q_we              = 1'b1;
            q_wdata.next_send = mqas_pkg::sat_add(q_rdata_q.next_send, cfg_i.q_ivl);
            q_wdata.cnt       = q_rdata_q.cnt + mqas_pkg::CNT_W'(1);
            cnt_d             = cnt_q + RCW'(1);
            q_adv             = 1'b1;
          end
        end else begin
          q_adv = 1'b1;
        end
        if (q_adv) begin
          if (qidx_q == QIW'(QUERY_SLOTS - 1)) begin
            state_d = mqas_pkg::ST_QEXP;
          end else begin
            qidx_d = qidx_q + QIW'(1);
          end
        end
      end

      // expirations of the walk, lowest slot first
      mqas_pkg::ST_QEXP: begin
        new_slot = mqas_pkg::SLOT_W'(exp_idx);
        if (expmask_q == '0) begin
          aidx_d  = '0;
          state_d = mqas_pkg::ST_AWALK;
        end else if (can_emit) begin
          emit_new           = 1'b1;
          new_ev             = mqas_pkg::EV_TIMED_OUT;
          expmask_d[exp_idx] = 1'b0;
        end
      end

      mqas_pkg::ST_AWALK: begin
        new_slot = mqas_pkg::SLOT_W'(aidx_q);
        if (!avalid_q[aidx_q]) begin
          a_adv = 1'b1;
        end else if (a_rdata_q.cnt >= cfg_i.a_max) begin
          // clamp so that a raised limit counts from the current limit
          a_we        = 1'b1;
          a_wdata.cnt = cfg_i.a_max;
          a_adv       = 1'b1;
        end else if (item_q.now >= a_rdata_q.next_send) begin
          if (full) begin
            state_d = mqas_pkg::ST_FIN;
          end else if (can_emit) begin
            emit_new          = 1'b1;
            new_ev            = mqas_pkg::EV_ANNOUNCE;
            a_we              = 1'b1;
            a_wdata.next_send = mqas_pkg::sat_add(item_q.now, cfg_i.a_ivl);
            a_wdata.cnt       = a_rdata_q.cnt + mqas_pkg::CNT_W'(1);
            cnt_d             = cnt_q + RCW'(1);
            a_adv             = 1'b1;
          end
        end else begin
          a_adv = 1'b1;
        end
        if (a_adv) begin
          if (aidx_q == AIW'(ANNOUNCE_SLOTS - 1)) begin
            state_d = mqas_pkg::ST_FIN;
          end else begin
            aidx_d = aidx_q + AIW'(1);
          end
        end
      end

      // release the held result as the final one of the item
      mqas_pkg::ST_FIN: begin
        if (!hold_v_q) begin
          state_d = mqas_pkg::ST_IDLE;
        end else if (res_ready_i) begin
          res_valid_o = 1'b1;
          hold_v_d    = 1'b0;
          state_d     = mqas_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mqas_pkg::ST_IDLE;
      end
    endcase

    // a new result pushes out the held one
    if (emit_new) begin
      res_valid_o = hold_v_q;
      hold_v_d    = 1'b1;
      hold_ev_d   = new_ev;
      hold_slot_d = new_slot;
    end

    // read the next slot while advancing, otherwise keep the current one
    if (state_q == mqas_pkg::ST_QWALK) begin
      q_raddr = q_adv ? qidx_q + QIW'(1) : qidx_q;
    end else begin
      q_raddr = '0;
    end
    if (state_q == mqas_pkg::ST_AWALK) begin
      a_raddr = a_adv ? aidx_q + AIW'(1) : aidx_q;
    end else begin
      a_raddr = '0;
    end
  end

  assign res_o = '{ev:   hold_ev_q,
                   slot: hold_slot_q,
                   last: (state_q == mqas_pkg::ST_FIN)};

  // a result leaves only when the output side can take it
  a_res_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_ready_i)
    else $error("result pushed while output register is busy");

  // an accepted item is decoded in the next cycle
  a_accept_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_ready_o) |=> (state_q == mqas_pkg::ST_CMD))
    else $error("accepted item not decoded");

  // the result budget of a tick is never exceeded
  a_budget : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RCW'(mqas_pkg::MAX_RESULTS))
    else $error("tick result budget exceeded");

  // no result is left behind once the block is idle again
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mqas_pkg::ST_IDLE) |-> !hold_v_q)
    else $error("held result lost at end of item");

  // query memory writes never happen while the query walk is stalled on the output
  a_stall_nowrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == mqas_pkg::ST_QWALK) && q_we) |-> q_adv)
    else $error("query entry written without advancing");

endmodule

`default_nettype wire
